// ===== hdl/lps_pkg.sv =====
// Shared types, command codes and field layout for the LED pattern sequencer.
// No dependencies; imported by lps_ramp and the top level.
package lps_pkg;

    // Default sizes, handed to the top level parameters
    localparam int STEP_DEPTH_DEF    = 64;
    localparam int SET_DEPTH_DEF     = 16;
    localparam int DURATION_BITS_DEF = 16;

    // Field widths fixed by the stream format
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 6;
    localparam int DUTY_W  = 8;
    localparam int DUR_IN_W = 16;
    localparam int STEP_W  = 6;
    localparam int REPS_W  = 8;
    localparam int NEXT_W  = 4;
    localparam int ASET_W  = 4;

    // Wide enough to hold any depth up to 256 plus one
    localparam int WIDE_IX_W = 9;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // Input beat layout (tdata), lowest bit first
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_LVL_BIT   = 6;
    localparam int IN_START_LSB = 7;
    localparam int IN_END_LSB   = 15;
    localparam int IN_DUR_LSB   = 23;
    localparam int IN_FIRST_LSB = 39;
    localparam int IN_LAST_LSB  = 45;
    localparam int IN_REPS_LSB  = 51;
    localparam int IN_NEXT_LSB  = 59;

    // Set entry layout in the set memory
    localparam int SET_ENTRY_W = 24;
    localparam int SE_FIRST_LSB = 0;
    localparam int SE_LAST_LSB  = 6;
    localparam int SE_REPS_LSB  = 12;
    localparam int SE_NEXT_LSB  = 20;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
    localparam logic [REPS_W-1:0] REPS_MAX  = 8'd255;

    // Commands carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 2'd0,
        CMD_WR_STEP   = 2'd1,
        CMD_WR_SET    = 2'd2,
        CMD_RESTART   = 2'd3
    } lps_cmd_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM    = 1'd1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TCHK,
        ST_ADV,
        ST_CHAIN,
        ST_RST,
        ST_EVAL,
        ST_GO,
        ST_WAIT,
        ST_DONE
    } lps_state_t;

endpackage

// ===== hdl/lps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lps_ramp.sv =====
// Ramp interpolation unit: start + (end - start) * elapsed / duration,
// truncated toward zero. One multiply, then eight restoring divide steps.
// Depends on lps_pkg.
module lps_ramp
    import lps_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     go,
    input  logic [DUTY_W-1:0]        start_val,
    input  logic [DUTY_W-1:0]        end_val,
    input  logic [DURATION_BITS-1:0] dur,
    input  logic [DURATION_BITS:0]   elapsed,
    output logic                     busy,
    output logic [DUTY_W-1:0]        duty
);

    localparam int NUM_W = DUTY_W + DURATION_BITS;

    logic                     busy_reg;
    logic [2:0]               cnt_reg;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [DURATION_BITS-1:0] dur_reg;
    logic [DUTY_W-1:0]        start_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic [DUTY_W-1:0]        q_reg, q_next;

    logic [DUTY_W:0]          diff;
    logic [DUTY_W:0]          mag9;
    logic [DURATION_BITS-1:0] e_clamp;
    logic [NUM_W-1:0]         shifted;

    // Operand set-up: signed difference and elapsed clamped to the duration
    always_comb begin
        diff    = {1'b0, end_val} - {1'b0, start_val};
        mag9    = diff[DUTY_W] ? (~diff + 1'b1) : diff;
        e_clamp = (elapsed > {1'b0, dur}) ? dur : elapsed[DURATION_BITS-1:0];
    end

    // One restoring step: quotient is below 256 since elapsed <= duration
    always_comb begin
        shifted  = {{DUTY_W{1'b0}}, dur_reg} << cnt_reg;
        num_next = num_reg;
        q_next   = q_reg;
        if (num_reg >= shifted) begin
            num_next        = num_reg - shifted;
            q_next[cnt_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (go) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd7;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 3'd1;
            if (cnt_reg == 3'd0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            num_reg   <= mag9[DUTY_W-1:0] * e_clamp;
            dur_reg   <= dur;
            start_reg <= start_val;
            neg_reg   <= diff[DUTY_W];
            zero_reg  <= (dur == '0);
            q_reg     <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            q_reg   <= q_next;
        end
    end

    // Zero duration holds the start value
    always_comb begin
        if (zero_reg) begin
            duty = start_reg;
        end else if (neg_reg) begin
            duty = start_reg - q_reg;
        end else begin
            duty = start_reg + q_reg;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hdl/led_pattern_sequencer_top.sv =====
// LED pattern sequencer: top level with the step/set memories and sequencer.
// Depends on lps_pkg, lps_ram and lps_ramp.
//
// Usage:
//   The s_ channel carries commands: tuser holds the command (tick of one
//   millisecond, write step, write set, restart set), tdata the entry fields.
//   Every accepted beat yields exactly one m_ beat with the LED drive, PWM
//   duty, active step and active set as they stand after the command.
//   cfg_wr_en/cfg_index/cfg_wdata write invert_output (0) and pwm_mode (1);
//   write them only while no command is in flight.
//   Throughput: one command at a time. A tick passes ST_TCHK, then ST_ADV
//   when its step time has run out and ST_CHAIN when it also chains to
//   another set; a restart to a stored set passes ST_RST; each command then
//   runs ST_EVAL, ST_GO, ST_WAIT and ST_DONE. The step and set memory reads
//   are registered and the ramp divider runs eight restoring steps.
//   The result waits in an output register; if the receiver stalls, the next
//   command is still accepted and finishes into that register once free.
//   Reset (aresetn low, synchronous) clears the step, set, repeat and time
//   state and both config registers; memory contents are kept and must be
//   written before use.
module led_pattern_sequencer_top
    import lps_pkg::*;
#(
    parameter int STEP_DEPTH    = STEP_DEPTH_DEF,
    parameter int SET_DEPTH     = SET_DEPTH_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] entry_index, [6] step_level, [14:7] step_start_value,
    // [22:15] step_end_value, [38:23] step_duration, [44:39] set_first_step,
    // [50:45] set_last_step, [58:51] set_repeats, [62:59] set_next, [63] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]      s_tuser,
    // Result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] pin_level, [8:1] duty_value, [14:9] active_step, [18:15] active_set,
    // [23:19] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic                  cfg_wdata
);

    localparam int STEP_AW = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
    localparam int SET_AW  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int STEP_ENTRY_W = 1 + 2 * DUTY_W + DURATION_BITS;
    localparam int SE_START_LSB = 1;
    localparam int SE_END_LSB   = 1 + DUTY_W;
    localparam int SE_DUR_LSB   = 1 + 2 * DUTY_W;
    localparam logic [WIDE_IX_W-1:0] STEP_LIM = WIDE_IX_W'(STEP_DEPTH);
    localparam logic [WIDE_IX_W-1:0] SET_LIM  = WIDE_IX_W'(SET_DEPTH);

    // ------------------------------------------------------------------
    // State
    lps_state_t               state_reg, state_next;
    logic [STEP_W-1:0]        cur_step_reg, cur_step_next;
    logic [IDX_W-1:0]         cur_set_reg, cur_set_next;
    logic [REPS_W-1:0]        rep_reg, rep_next;
    logic [DURATION_BITS:0]   elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     invert_reg, pwm_reg;
    logic                     step_hit_reg, set_hit_reg;
    logic                     level_reg, level_next;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     out_load;

    // Memory ports
    logic                     step_wr_en, set_wr_en;
    logic [STEP_AW-1:0]       step_wr_addr, step_rd_addr;
    logic [SET_AW-1:0]        set_wr_addr, set_rd_addr;
    logic [STEP_ENTRY_W-1:0]  step_wr_data, step_rd_data, step_q;
    logic [SET_ENTRY_W-1:0]   set_wr_data, set_rd_data, set_q;
    logic [WIDE_IX_W-1:0]     set_rd_wide;

    // Decoded input beat
    logic                     in_accept;
    lps_cmd_t                 in_cmd;
    logic [WIDE_IX_W-1:0]     in_ix_wide;
    logic [31:0]              in_dur32;

    // Ramp unit
    logic                     ramp_go, ramp_busy;
    logic [DUTY_W-1:0]        ramp_duty;

    // Fields of the entries just read
    logic [DURATION_BITS-1:0] q_dur;
    logic [STEP_W-1:0]        q_first, q_last;
    logic [REPS_W-1:0]        q_reps;
    logic [NEXT_W-1:0]        q_next_set;

    // Advance arithmetic
    logic [STEP_W:0]          step_p1;
    logic                     wrap;
    logic [REPS_W-1:0]        rep_inc, rep_adv;
    logic [DUTY_W-1:0]        duty_out;
    logic                     pin_out;

    assign in_accept  = s_tvalid && s_tready;
    assign in_cmd     = lps_cmd_t'(s_tuser);
    assign in_ix_wide = {{(WIDE_IX_W - IDX_W){1'b0}}, s_tdata[IN_IDX_LSB +: IDX_W]};
    assign in_dur32   = {16'b0, s_tdata[IN_DUR_LSB +: DUR_IN_W]};

    // ------------------------------------------------------------------
    // Memory writes straight from the accepted beat
    assign step_wr_en   = in_accept && (in_cmd == CMD_WR_STEP) && (in_ix_wide < STEP_LIM);
    assign step_wr_addr = in_ix_wide[STEP_AW-1:0];
    assign step_wr_data = {in_dur32[DURATION_BITS-1:0],
                           s_tdata[IN_END_LSB +: DUTY_W],
                           s_tdata[IN_START_LSB +: DUTY_W],
                           s_tdata[IN_LVL_BIT]};

    assign set_wr_en    = in_accept && (in_cmd == CMD_WR_SET) && (in_ix_wide < SET_LIM);
    assign set_wr_addr  = in_ix_wide[SET_AW-1:0];
    assign set_wr_data  = {s_tdata[IN_NEXT_LSB +: NEXT_W],
                           s_tdata[IN_REPS_LSB +: REPS_W],
                           s_tdata[IN_LAST_LSB +: STEP_W],
                           s_tdata[IN_FIRST_LSB +: STEP_W]};

    // Step memory is always read at the current step
    assign step_rd_addr = WIDE_IX_W'(cur_step_reg) < STEP_LIM
                        ? step_rd_addr_of(cur_step_reg) : '0;

    function automatic logic [STEP_AW-1:0] step_rd_addr_of(input logic [STEP_W-1:0] s);
        logic [WIDE_IX_W-1:0] w;
        w = {{(WIDE_IX_W - STEP_W){1'b0}}, s};
        return w[STEP_AW-1:0];
    endfunction

    assign set_rd_addr = set_rd_wide[SET_AW-1:0];

    // Entries outside the stores read as zero
    assign step_q = step_hit_reg ? step_rd_data : '0;
    assign set_q  = set_hit_reg ? set_rd_data : '0;

    assign q_dur      = step_q[SE_DUR_LSB +: DURATION_BITS];
    assign q_first    = set_q[SE_FIRST_LSB +: STEP_W];
    assign q_last     = set_q[SE_LAST_LSB +: STEP_W];
    assign q_reps     = set_q[SE_REPS_LSB +: REPS_W];
    assign q_next_set = set_q[SE_NEXT_LSB +: NEXT_W];

    lps_ram #(
        .WIDTH (STEP_ENTRY_W),
        .DEPTH (STEP_DEPTH)
    ) u_step_ram (
        .aclk    (aclk),
        .wr_en   (step_wr_en),
        .wr_addr (step_wr_addr),
        .wr_data (step_wr_data),
        .rd_addr (step_rd_addr),
        .rd_data (step_rd_data)
    );

    lps_ram #(
        .WIDTH (SET_ENTRY_W),
        .DEPTH (SET_DEPTH)
    ) u_set_ram (
        .aclk    (aclk),
        .wr_en   (set_wr_en),
        .wr_addr (set_wr_addr),
        .wr_data (set_wr_data),
        .rd_addr (set_rd_addr),
        .rd_data (set_rd_data)
    );

    lps_ramp #(
        .DURATION_BITS (DURATION_BITS)
    ) u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (ramp_go),
        .start_val (step_q[SE_START_LSB +: DUTY_W]),
        .end_val   (step_q[SE_END_LSB +: DUTY_W]),
        .dur       (q_dur),
        .elapsed   (elapsed_reg),
        .busy      (ramp_busy),
        .duty      (ramp_duty)
    );

    // ------------------------------------------------------------------
    // Advance: next step, wrap and repeat counting
    always_comb begin
        step_p1 = {1'b0, cur_step_reg} + 1'b1;
        wrap    = step_p1 > {1'b0, q_last};
        rep_inc = (rep_reg == REPS_MAX) ? rep_reg : rep_reg + 1'b1;
        rep_adv = wrap ? rep_inc : rep_reg;
    end

    // Result of the current step after inversion: the pin in level mode, the duty in PWM mode
    always_comb begin
        pin_out  = pwm_reg ? 1'b0 : (level_reg ^ invert_reg);
        duty_out = '0;
        if (pwm_reg) begin
            duty_out = invert_reg ? (DUTY_FULL - ramp_duty) : ramp_duty;
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------
    // Sequencer: next state and state updates
    always_comb begin
        state_next    = state_reg;
        cur_step_next = cur_step_reg;
        cur_set_next  = cur_set_reg;
        rep_next      = rep_reg;
        elapsed_next  = elapsed_reg;
        idx_next      = idx_reg;
        level_next    = level_reg;
        set_rd_wide   = {{(WIDE_IX_W - IDX_W){1'b0}}, cur_set_reg};
        ramp_go       = 1'b0;
        s_tready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                set_rd_wide = in_ix_wide;
                if (in_accept) begin
                    idx_next = s_tdata[IN_IDX_LSB +: IDX_W];
                    unique case (in_cmd)
                        CMD_TICK: begin
                            if (elapsed_reg != '1) begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                            state_next = ST_TCHK;
                        end
                        CMD_RESTART: begin
                            state_next = (in_ix_wide < SET_LIM) ? ST_RST : ST_EVAL;
                        end
                        default: begin
                            state_next = ST_EVAL;
                        end
                    endcase
                end
            end
            ST_TCHK: begin
                // step entry read at the current step is here
                set_rd_wide = {{(WIDE_IX_W - IDX_W){1'b0}}, cur_set_reg};
                state_next  = (elapsed_reg > {1'b0, q_dur}) ? ST_ADV : ST_EVAL;
            end
            ST_ADV: begin
                elapsed_next = '0;
                set_rd_wide  = {{(WIDE_IX_W - NEXT_W){1'b0}}, q_next_set};
                if (rep_adv >= q_reps) begin
                    cur_set_next = {{(IDX_W - NEXT_W){1'b0}}, q_next_set};
                    rep_next     = '0;
                    state_next   = ST_CHAIN;
                end else begin
                    cur_step_next = wrap ? q_first : step_p1[STEP_W-1:0];
                    rep_next      = rep_adv;
                    state_next    = ST_EVAL;
                end
            end
            ST_CHAIN: begin
                cur_step_next = q_first;
                state_next    = ST_EVAL;
            end
            ST_RST: begin
                cur_set_next  = idx_reg;
                cur_step_next = q_first;
                elapsed_next  = '0;
                rep_next      = '0;
                state_next    = ST_EVAL;
            end
            ST_EVAL: begin
                // read issued at the (updated) current step
                state_next = ST_GO;
            end
            ST_GO: begin
                ramp_go    = 1'b1;
                level_next = step_q[0];
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (!ramp_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_step_reg <= '0;
            cur_set_reg  <= '0;
            rep_reg      <= '0;
            elapsed_reg  <= '0;
            invert_reg   <= 1'b0;
            pwm_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_step_reg <= cur_step_next;
            cur_set_reg  <= cur_set_next;
            rep_reg      <= rep_next;
            elapsed_reg  <= elapsed_next;
            // configuration writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_INVERT: invert_reg <= cfg_wdata;
                    CFG_PWM:    pwm_reg    <= cfg_wdata;
                    default:    ;
                endcase
            end
            // output register handshake
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload and read-range flags, aligned with the registered memory reads
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        level_reg    <= level_next;
        step_hit_reg <= WIDE_IX_W'(cur_step_reg) < STEP_LIM;
        set_hit_reg  <= set_rd_wide < SET_LIM;
        if (out_load) begin
            m_tdata_reg <= {{(M_TDATA_W - 1 - DUTY_W - STEP_W - ASET_W){1'b0}},
                            cur_set_reg[ASET_W-1:0], cur_step_reg, duty_out, pin_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // One command at a time: no beat is taken right after one was accepted
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in flight");

    // An advance always restarts the step time
    a_adv_clears_time: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADV |=> elapsed_reg == '0)
        else $error("elapsed time not cleared on advance");

    // Results are only taken from an idle ramp unit
    a_ramp_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> !ramp_busy)
        else $error("result formed while ramp unit busy");
`endif

endmodule
